### hw/rtl/c2d_pkg.sv
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared types and constants for the 2D convolution layer core.
// ----------------------------------------------------------------------------
package c2d_pkg;

  localparam int DEF_MAX_IN_CH  = 16;
  localparam int DEF_MAX_OUT_CH = 16;
  localparam int DEF_MAX_KERNEL = 7;
  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_MAX_COLS   = 64;

  // signed width for kernel sample positions (covers row*stride and image bounds)
  localparam int POS_W   = 12;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    FN_LOAD_W = 2'd0,
    FN_LOAD_B = 2'd1,
    FN_LOAD_X = 2'd2,
    FN_CALC   = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_CH   = 3'd0,
    REG_OUT_CH  = 3'd1,
    REG_KSIZE   = 3'd2,
    REG_STRIDE  = 3'd3,
    REG_ROWS    = 3'd4,
    REG_COLS    = 3'd5,
    REG_ENABLE  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         out_channel;
    logic [3:0]         in_channel;
    logic [5:0]         tap;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic               saturated;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    in_item_t item;
    logic     in_range;
  } cmd_t;

  typedef struct packed {
    logic [4:0] in_channels;
    logic [4:0] out_channels;
    logic [2:0] kernel_size;
    logic [2:0] stride;
    logic [6:0] in_rows;
    logic [6:0] in_cols;
    logic       layer_enable;
  } cfg_t;

endpackage

### hw/rtl/conv2d_multichannel_same_pad_core.sv
// ----------------------------------------------------------------------------
// conv2d_multichannel_same_pad_core
// Multi-channel strided 2D convolution with zero padding, Q8.8 in, Q16.16 out.
// ----------------------------------------------------------------------------
// Load transactions (weight, bias, sample) are written to their stores as the back end
// takes them. A compute transaction runs one multiply-accumulate per cycle through a
// single shared MAC fed by the weight and sample memories, over in_channels * k * k
// steps (k the effective kernel side); a disabled layer passes the addressed sample
// through instead. A two-entry command queue lets new transactions be accepted while
// a compute runs, and the result register holds one answer until it is popped.
module conv2d_multichannel_same_pad_core import c2d_pkg::*; #(
  parameter int MAX_IN_CH  = DEF_MAX_IN_CH,
  parameter int MAX_OUT_CH = DEF_MAX_OUT_CH,
  parameter int MAX_KERNEL = DEF_MAX_KERNEL,
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  in_item_t             in_data,
  output logic                 out_empty,
  input  logic                 out_pop,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t cfg_r;
  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_channels  <= 5'd1;
      cfg_r.out_channels <= 5'd1;
      cfg_r.kernel_size  <= 3'd3;
      cfg_r.stride       <= 3'd1;
      cfg_r.in_rows      <= 7'd64;
      cfg_r.in_cols      <= 7'd64;
      cfg_r.layer_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_IN_CH:  cfg_r.in_channels  <= cfg_wdata[4:0];
        REG_OUT_CH: cfg_r.out_channels <= cfg_wdata[4:0];
        REG_KSIZE:  cfg_r.kernel_size  <= cfg_wdata[2:0];
        REG_STRIDE: cfg_r.stride       <= cfg_wdata[2:0];
        REG_ROWS:   cfg_r.in_rows      <= cfg_wdata[6:0];
        REG_COLS:   cfg_r.in_cols      <= cfg_wdata[6:0];
        REG_ENABLE: cfg_r.layer_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  c2d_front #(
    .MAX_IN_CH(MAX_IN_CH), .MAX_OUT_CH(MAX_OUT_CH), .MAX_KERNEL(MAX_KERNEL),
    .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)
  ) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .cmd_valid, .cmd, .cmd_pop
  );

  c2d_back #(
    .MAX_IN_CH(MAX_IN_CH), .MAX_OUT_CH(MAX_OUT_CH), .MAX_KERNEL(MAX_KERNEL),
    .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)
  ) u_back (
    .clk, .rst_n, .cfg(cfg_r), .cmd_valid, .cmd, .cmd_pop,
    .out_empty, .out_pop, .out_data
  );

endmodule

### hw/rtl/c2d_front.sv
// ----------------------------------------------------------------------------
// c2d_front
// Accepts input transactions, range-checks them and queues them for the back.
// ----------------------------------------------------------------------------
module c2d_front import c2d_pkg::*; #(
  parameter int MAX_IN_CH  = DEF_MAX_IN_CH,
  parameter int MAX_OUT_CH = DEF_MAX_OUT_CH,
  parameter int MAX_KERNEL = DEF_MAX_KERNEL,
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_data,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_pop
);

  localparam int KSQ = MAX_KERNEL * MAX_KERNEL;

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       ch_ok, pos_ok;
  cmd_t       cls;
  logic       do_push, do_pop;

  // classify: does the item address a real store entry
  always_comb begin
    ch_ok  = 32'(in_data.in_channel) < MAX_IN_CH;
    pos_ok = ch_ok && (32'(in_data.row) < MAX_ROWS) && (32'(in_data.col) < MAX_COLS);
    cls.item = in_data;
    case (func_t'(in_data.func))
      FN_LOAD_W: cls.in_range = (32'(in_data.out_channel) < MAX_OUT_CH) && ch_ok &&
                                (32'(in_data.tap) < KSQ);
      FN_LOAD_B: cls.in_range = 32'(in_data.out_channel) < MAX_OUT_CH;
      default:   cls.in_range = pos_ok;
    endcase
  end

  assign in_full   = cnt_r == 2'd2;
  assign cmd_valid = cnt_r != 2'd0;
  assign cmd       = q_r[rp_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= cls;
  end

endmodule

### hw/rtl/c2d_back.sv
// ----------------------------------------------------------------------------
// c2d_back
// Stores weights, biases and samples; runs the MAC sequencer for computes.
// ----------------------------------------------------------------------------
module c2d_back import c2d_pkg::*; #(
  parameter int MAX_IN_CH  = DEF_MAX_IN_CH,
  parameter int MAX_OUT_CH = DEF_MAX_OUT_CH,
  parameter int MAX_KERNEL = DEF_MAX_KERNEL,
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  localparam int KSQ     = MAX_KERNEL * MAX_KERNEL;
  localparam int W_DEPTH = MAX_OUT_CH * MAX_IN_CH * KSQ;
  localparam int X_DEPTH = MAX_IN_CH * MAX_ROWS * MAX_COLS;
  localparam int W_AW    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int X_AW    = (X_DEPTH > 1) ? $clog2(X_DEPTH) : 1;
  localparam int B_AW    = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
  localparam int CW      = $clog2(MAX_IN_CH + 1);
  localparam int TW      = $clog2(KSQ + 1);
  localparam int ACC_W   = 34 + $clog2(MAX_IN_CH * KSQ + 1);
  localparam int KTOP    = (MAX_KERNEL % 2 == 1) ? MAX_KERNEL : MAX_KERNEL - 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PASS, ST_SETUP, ST_MAC, ST_DRAIN, ST_DONE
  } state_t;

  // stores
  logic [15:0] w_mem [W_DEPTH];
  logic [31:0] b_mem [MAX_OUT_CH];
  logic [15:0] x_mem [X_DEPTH];
  logic [15:0] w_q, x_q;
  logic [31:0] b_q;
  logic        w_we, b_we, x_we, w_re, b_re, x_re;
  logic [W_AW-1:0] w_waddr, w_raddr;
  logic [X_AW-1:0] x_waddr, x_raddr;
  logic [B_AW-1:0] b_addr;

  state_t state_r;
  cmd_t   cur_r;
  logic   conv_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [POS_W-1:0] cr_r, cc_r;
  logic [CW-1:0] c_r;
  logic [3:0]    a_r, b_r;
  logic [TW-1:0] t_r;
  logic          s1_vld_r, s1_last_r, s2_vld_r, s2_last_r;
  logic signed [31:0] prod_r;
  out_item_t     res_r;
  logic          res_valid_r;

  // effective configuration
  logic [CW-1:0] nin;
  logic [B_AW:0] nout;
  logic [2:0]    str;
  logic signed [POS_W-1:0] nr, nc;
  logic [3:0]    k, half;
  always_comb begin
    nin  = (cfg.in_channels == 5'd0) ? CW'(1) :
           (32'(cfg.in_channels) > MAX_IN_CH) ? CW'(MAX_IN_CH) : CW'(cfg.in_channels);
    nout = (cfg.out_channels == 5'd0) ? (B_AW+1)'(1) :
           (32'(cfg.out_channels) > MAX_OUT_CH) ? (B_AW+1)'(MAX_OUT_CH) :
           (B_AW+1)'(cfg.out_channels);
    str  = (cfg.stride == 3'd0) ? 3'd1 : cfg.stride;
    nr   = (cfg.in_rows == 7'd0) ? POS_W'(1) :
           (32'(cfg.in_rows) > MAX_ROWS) ? POS_W'(MAX_ROWS) : POS_W'(cfg.in_rows);
    nc   = (cfg.in_cols == 7'd0) ? POS_W'(1) :
           (32'(cfg.in_cols) > MAX_COLS) ? POS_W'(MAX_COLS) : POS_W'(cfg.in_cols);
    k    = (32'({1'b0, cfg.kernel_size | 3'd1}) > KTOP) ? 4'(KTOP) :
           {1'b0, cfg.kernel_size | 3'd1};
    half = k >> 1;
  end

  // current kernel position
  logic signed [POS_W-1:0] pi, pj;
  logic pos_ok, step_last;
  always_comb begin
    pi = cr_r + POS_W'(a_r) - POS_W'(half);
    pj = cc_r + POS_W'(b_r) - POS_W'(half);
    pos_ok = (pi >= 0) && (pi < nr) && (pj >= 0) && (pj < nc);
    step_last = (c_r == nin - CW'(1)) && (a_r == k - 4'd1) && (b_r == k - 4'd1);
  end

  // store port control
  always_comb begin
    cmd_pop = (state_r == ST_IDLE) && cmd_valid;
    w_we = cmd_pop && cmd.in_range && (func_t'(cmd.item.func) == FN_LOAD_W);
    b_we = cmd_pop && cmd.in_range && (func_t'(cmd.item.func) == FN_LOAD_B);
    x_we = cmd_pop && cmd.in_range && (func_t'(cmd.item.func) == FN_LOAD_X);
    b_re = cmd_pop && (func_t'(cmd.item.func) == FN_CALC);
    w_re = (state_r == ST_MAC);
    x_re = (state_r == ST_MAC) || b_re;
    w_waddr = W_AW'((32'(cmd.item.out_channel) * MAX_IN_CH + 32'(cmd.item.in_channel)) * KSQ
                    + 32'(cmd.item.tap));
    x_waddr = X_AW'((32'(cmd.item.in_channel) * MAX_ROWS + 32'(cmd.item.row)) * MAX_COLS
                    + 32'(cmd.item.col));
    b_addr  = B_AW'(cmd.item.out_channel);
    w_raddr = W_AW'((32'(cur_r.item.out_channel) * MAX_IN_CH + 32'(c_r)) * KSQ + 32'(t_r));
    x_raddr = (state_r == ST_MAC) ?
              X_AW'((32'(c_r) * MAX_ROWS + 32'(pi)) * MAX_COLS + 32'(pj)) : x_waddr;
  end

  // weight store
  always_ff @(posedge clk) begin
    if (w_we) w_mem[w_waddr] <= cmd.item.value[15:0];
    if (w_re) w_q <= w_mem[w_raddr];
  end

  // bias store
  always_ff @(posedge clk) begin
    if (b_we) b_mem[b_addr] <= cmd.item.value;
    if (b_re) b_q <= b_mem[b_addr];
  end

  // sample store
  always_ff @(posedge clk) begin
    if (x_we) x_mem[x_waddr] <= cmd.item.value[15:0];
    if (x_re) x_q <= x_mem[x_raddr];
  end

  // result formatting
  logic        sat;
  logic [31:0] clip;
  always_comb begin
    sat  = conv_r && !((&acc_r[ACC_W-1:31]) || !(|acc_r[ACC_W-1:31]));
    clip = sat ? (acc_r[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF) : acc_r[31:0];
  end

  // sequencer, MAC pipeline and result slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      res_valid_r <= 1'b0;
      s1_vld_r    <= 1'b0;
      s1_last_r   <= 1'b0;
      s2_vld_r    <= 1'b0;
      s2_last_r   <= 1'b0;
    end else begin
      // the done state refills the slot itself when it is popped
      if (out_pop && res_valid_r && state_r != ST_DONE) res_valid_r <= 1'b0;
      s1_vld_r  <= (state_r == ST_MAC) && pos_ok;
      s1_last_r <= (state_r == ST_MAC) && step_last;
      s2_vld_r  <= s1_vld_r;
      s2_last_r <= s1_last_r;
      prod_r    <= $signed(w_q) * $signed(x_q);
      if (s2_vld_r) acc_r <= acc_r + ACC_W'(prod_r);
      unique case (state_r)
        ST_IDLE: begin
          if (cmd_pop && func_t'(cmd.item.func) == FN_CALC) begin
            cur_r  <= cmd;
            conv_r <= cfg.layer_enable;
            cr_r   <= POS_W'(cmd.item.row) * POS_W'(str);
            cc_r   <= POS_W'(cmd.item.col) * POS_W'(str);
            state_r <= cfg.layer_enable ? ST_SETUP : ST_PASS;
          end
        end
        ST_PASS: begin
          acc_r   <= cur_r.in_range ? ACC_W'($signed({x_q, 8'h00})) : '0;
          state_r <= ST_DONE;
        end
        ST_SETUP: begin
          c_r <= '0;
          a_r <= '0;
          b_r <= '0;
          t_r <= '0;
          if ((B_AW+1)'(cur_r.item.out_channel) < nout && cr_r < nr && cc_r < nc &&
              32'(cur_r.item.out_channel) < MAX_OUT_CH) begin
            acc_r   <= ACC_W'($signed(b_q));
            state_r <= ST_MAC;
          end else begin
            acc_r   <= '0;
            state_r <= ST_DONE;
          end
        end
        ST_MAC: begin
          if (b_r == k - 4'd1) begin
            b_r <= '0;
            if (a_r == k - 4'd1) begin
              a_r <= '0;
              t_r <= '0;
              c_r <= c_r + CW'(1);
            end else begin
              a_r <= a_r + 4'd1;
              t_r <= t_r + TW'(1);
            end
          end else begin
            b_r <= b_r + 4'd1;
            t_r <= t_r + TW'(1);
          end
          if (step_last) state_r <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (s2_last_r) state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!res_valid_r || out_pop) begin
            res_r.out_value <= clip;
            res_r.saturated <= sat;
            res_valid_r     <= 1'b1;
            state_r         <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_empty = !res_valid_r;
  assign out_data  = res_r;

  // no MAC traffic outside a convolution
  a_no_mac_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !s1_vld_r || $past(state_r) == ST_MAC)
    else $error("MAC read issued outside MAC state");
  // the last step always ends in the drain state
  a_last_drain: assert property (@(posedge clk) disable iff (!rst_n)
    s2_last_r |-> state_r == ST_DRAIN)
    else $error("last product seen outside drain");
  // a waiting result is never overwritten
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && !out_pop) |=> res_valid_r && $stable(res_r))
    else $error("pending result overwritten");
  // pass-through never reports saturation
  a_pass_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !conv_r) |-> !sat)
    else $error("saturation flagged on pass-through");

endmodule

### tb/sv/tb_conv2d_multichannel_same_pad_core.sv
// ----------------------------------------------------------------------------
// tb_conv2d_multichannel_same_pad_core
// Self-checking bench for the convolution core: a queue-fed driver pushes load
// and compute transactions; a monitor pops results and compares them against
// an in-bench convolution predictor across several register settings.
// ----------------------------------------------------------------------------
module tb_conv2d_multichannel_same_pad_core;
  import c2d_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NIC = DEF_MAX_IN_CH;
  localparam int NOC = DEF_MAX_OUT_CH;
  localparam int MK  = DEF_MAX_KERNEL;
  localparam int KSQ = MK * MK;
  localparam int NR  = DEF_MAX_ROWS;
  localparam int NC  = DEF_MAX_COLS;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_item_t in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  conv2d_multichannel_same_pad_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_data(in_data), .out_empty(out_empty), .out_pop(out_pop),
    .out_data(out_data), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [15:0] wgt_mem [NOC*NIC*KSQ];
  logic [31:0] bias_mem [NOC];
  logic [15:0] smp_mem [NIC*NR*NC];
  bit          smp_ok [NIC*NR*NC];
  bit          wgt_ok [NOC*NIC*KSQ];
  bit          bias_ok [NOC];
  cfg_t        cfg;

  in_item_t  pending_q [$];
  out_item_t result_q [$];
  int errors = 0;
  int send_idle = 0;     // percent
  int recv_stall = 0;    // percent
  int phase_no = -1;
  bit hold_done = 1'b0;
  int stall_cnt = 0;

  function automatic int clamp1(int v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int eff_k();
    int k;
    k = int'(cfg.kernel_size) | 1;
    return (k > MK) ? MK : k;
  endfunction

  // expected value of one compute transaction
  function automatic out_item_t conv_result(in_item_t it);
    out_item_t r;
    longint acc;
    int nin, nout, st, nr, nc, k, h, cr, cc, i, j;
    r = '0;
    acc = 0;
    if (!cfg.layer_enable) begin
      acc = longint'($signed(smp_mem[(it.in_channel*NR + it.row)*NC + it.col])) * 256;
      r.out_value = acc[31:0];
      return r;
    end
    nin = clamp1(cfg.in_channels, NIC);
    nout = clamp1(cfg.out_channels, NOC);
    st = clamp1(cfg.stride, 7);
    nr = clamp1(cfg.in_rows, NR);
    nc = clamp1(cfg.in_cols, NC);
    k = eff_k();
    h = k / 2;
    cr = it.row * st;
    cc = it.col * st;
    if (it.out_channel < nout && cr < nr && cc < nc) begin
      acc = longint'($signed(bias_mem[it.out_channel]));
      for (int c = 0; c < nin; c++)
        for (int a = 0; a < k; a++)
          for (int b = 0; b < k; b++) begin
            i = cr + a - h;
            j = cc + b - h;
            if (i >= 0 && i < nr && j >= 0 && j < nc)
              acc += longint'($signed(wgt_mem[(it.out_channel*NIC + c)*KSQ + a*k + b]))
                   * longint'($signed(smp_mem[(c*NR + i)*NC + j]));
          end
      if (acc > 64'sd2147483647) begin
        acc = 64'sd2147483647; r.saturated = 1'b1;
      end else if (acc < -64'sd2147483648) begin
        acc = -64'sd2147483648; r.saturated = 1'b1;
      end
      r.out_value = acc[31:0];
    end
    return r;
  endfunction

  // apply one accepted transaction to the predictor
  task automatic predict(in_item_t it);
    case (func_t'(it.func))
      FN_LOAD_W: begin
        if (it.tap < KSQ) wgt_mem[(it.out_channel*NIC + it.in_channel)*KSQ + it.tap] =
          it.value[15:0];
      end
      FN_LOAD_B: bias_mem[it.out_channel] = it.value;
      FN_LOAD_X: smp_mem[(it.in_channel*NR + it.row)*NC + it.col] = it.value[15:0];
      FN_CALC: result_q.push_back(conv_result(it));
      default: ;
    endcase
  endtask

  // rising-edge sample of the handshakes
  logic in_full_s = 1'b1;
  always @(posedge clk) begin
    in_full_s <= in_full;
  end

  // driver: offers the head of the pending queue
  always @(negedge clk) begin
    if (rst_n && in_push && !in_full_s) begin
      predict(pending_q.pop_front());
    end
    if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
      in_push <= 1'b1;
      in_data <= pending_q[0];
    end else begin
      in_push <= 1'b0;
    end
  end

  // monitor: compare popped results with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (result_q.size() == 0) begin
        $error("unexpected result out_value=%0h", out_data.out_value);
        errors++;
      end else begin
        out_item_t e;
        e = result_q.pop_front();
        if (out_data.out_value !== e.out_value) begin
          $error("out_value exp %0h got %0h", e.out_value, out_data.out_value);
          errors++;
        end
        if (out_data.saturated !== e.saturated) begin
          $error("saturated exp %0b got %0b", e.saturated, out_data.saturated);
          errors++;
        end
      end
    end
  end

  // receiver pop control; a phase-2 hold-off counts up in this same process
  always @(negedge clk) begin
    if (phase_no == 2 && !hold_done) begin
      out_pop <= 1'b0;
      if (stall_cnt >= 3000) hold_done = 1'b1;
      stall_cnt++;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_stall);
    end
  end

  function automatic in_item_t mk(func_t f, int oc, int ic, int tp, int r, int c,
                                  logic [31:0] v);
    in_item_t it;
    it.func = f; it.out_channel = 4'(oc); it.in_channel = 4'(ic); it.tap = 6'(tp);
    it.row = 6'(r); it.col = 6'(c); it.value = v;
    return it;
  endfunction

  // loads every entry a compute under the current setting can touch
  task automatic fill_stores(int nin, int nout, int rows, int cols, int k, bit extreme);
    logic [31:0] v;
    for (int o = 0; o < nout; o++) begin
      v = extreme ? 32'h7fff_0000 : $urandom;
      if (!bias_ok[o]) pending_q.push_back(mk(FN_LOAD_B, o, $urandom, 0, 0, 0, v));
      bias_ok[o] = 1;
      for (int c = 0; c < nin; c++)
        for (int t = 0; t < k*k; t++) begin
          v = extreme ? {16'($urandom), 16'h7fff} : $urandom;
          if (!wgt_ok[(o*NIC + c)*KSQ + t]) pending_q.push_back(mk(FN_LOAD_W, o, c, t, 0, 0, v));
          wgt_ok[(o*NIC + c)*KSQ + t] = 1;
        end
    end
    for (int c = 0; c < nin; c++)
      for (int r = 0; r < rows; r++)
        for (int cl = 0; cl < cols; cl++)
          if (!smp_ok[(c*NR + r)*NC + cl]) begin
            v = extreme ? {16'($urandom), 16'h7fff} : $urandom;
            pending_q.push_back(mk(FN_LOAD_X, $urandom, c, $urandom, r, cl, v));
            smp_ok[(c*NR + r)*NC + cl] = 1;
          end
  endtask

  task automatic write_reg(reg_idx_t idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= CFG_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IN_CH:  cfg.in_channels = 5'(val);
      REG_OUT_CH: cfg.out_channels = 5'(val);
      REG_KSIZE:  cfg.kernel_size = 3'(val);
      REG_STRIDE: cfg.stride = 3'(val);
      REG_ROWS:   cfg.in_rows = 7'(val);
      REG_COLS:   cfg.in_cols = 7'(val);
      default:    cfg.layer_enable = val[0];
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || result_q.size() != 0) @(negedge clk);
    repeat (1000) @(negedge clk);
  endtask

  // one phase: set registers, load what is read, then computes
  task automatic run_phase(int nin, int nout, int k, int st, int rows, int cols, bit en,
                           int n_calc, bit extreme);
    int orr, occ, ke;
    drain();
    write_reg(REG_IN_CH, nin); write_reg(REG_OUT_CH, nout); write_reg(REG_KSIZE, k);
    write_reg(REG_STRIDE, st); write_reg(REG_ROWS, rows); write_reg(REG_COLS, cols);
    write_reg(REG_ENABLE, en);
    ke = eff_k();
    fill_stores(clamp1(nin, NIC), clamp1(nout, NOC), clamp1(rows, NR), clamp1(cols, NC),
                ke, extreme);
    orr = (clamp1(rows, NR) + clamp1(st, 7) - 1) / clamp1(st, 7);
    occ = (clamp1(cols, NC) + clamp1(st, 7) - 1) / clamp1(st, 7);
    for (int n = 0; n < n_calc; n++) begin
      int r, c, o, ic;
      // mostly in-range positions, some beyond the image or channel count
      o = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(clamp1(nout,NOC)-1);
      r = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(orr-1);
      c = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(occ-1);
      ic = $urandom_range(clamp1(nin, NIC)-1);
      if (!en) begin
        r = $urandom_range(clamp1(rows, NR)-1);
        c = $urandom_range(clamp1(cols, NC)-1);
      end
      pending_q.push_back(mk(FN_CALC, o, ic, $urandom, r, c, $urandom));
    end
  endtask

  initial begin
    cfg = '{in_channels:1, out_channels:1, kernel_size:3, stride:1,
            in_rows:64, in_cols:64, layer_enable:1};
    foreach (wgt_mem[i]) wgt_mem[i] = '0;
    foreach (bias_mem[i]) bias_mem[i] = '0;
    foreach (smp_mem[i]) smp_mem[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: tiny image, saturating extremes, out-of-store loads ignored
    run_phase(1, 1, 3, 1, 4, 4, 1, 6, 1);
    pending_q.push_back(mk(FN_LOAD_W, 0, 0, 63, 0, 0, 32'h1234));
    pending_q.push_back(mk(FN_CALC, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(FN_CALC, 0, 0, 0, 3, 3, 0));
    pending_q.push_back(mk(FN_CALC, 15, 0, 0, 63, 63, 0));
    run_phase(2, 2, 1, 4, 1, 1, 1, 4, 0);
    run_phase(0, 0, 0, 0, 0, 0, 1, 3, 0);
    run_phase(1, 1, 7, 7, 8, 8, 0, 6, 0);
    run_phase(31, 1, 1, 1, 1, 1, 1, 4, 1);

    // random phases under each idling pattern
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 48; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 48; end
        default: begin send_idle = 28; recv_stall = 28; end
      endcase
      phase_no = p;
      run_phase($urandom_range(2,1), $urandom_range(2,1), 2*$urandom_range(3)+1,
                $urandom_range(4,1), $urandom_range(8,1), $urandom_range(8,1),
                $urandom_range(7) != 0, 24, 0);
    end
    send_idle = 0; recv_stall = 0;
    run_phase(1, 4, 3, 2, 10, 10, 1, 20, 0);
    run_phase(16, 1, 1, 1, 2, 2, 1, 10, 0);
    run_phase(1, 1, 3, 1, 12, 12, 0, 20, 0);
    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit
  initial begin
    #30ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
